### rtl/conv3x3_saturating_image_filter_defines.svh
// Assertion macros used by the checker file of the 3x3 image filter.
// Depends on nothing; take it in with `include by its bare file name.
`ifndef CONV3X3_SATURATING_IMAGE_FILTER_DEFINES_SVH
`define CONV3X3_SATURATING_IMAGE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define C3X3F_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("c3x3f check failed");

// Next-cycle implication, disabled while reset is high.
`define C3X3F_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("c3x3f check failed");

// Same-cycle implication that also holds across reset.
`define C3X3F_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("c3x3f check failed");

`endif

### rtl/c3x3f_pkg.sv
// Types and constants of the 3x3 saturating image filter.
// Used by the tap cell, the output queue and the top level; depends on nothing.
package c3x3f_pkg;

   localparam int PIX_W      = 8;
   localparam int COEF_W     = 16;
   localparam int TAPS       = 9;
   localparam int WIN_W      = PIX_W * TAPS;
   localparam int COORD_W    = 10;
   localparam int ROW_COEFS  = 3;
   localparam int KROW_W     = COEF_W * ROW_COEFS;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = KROW_W;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_TOP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MIDDLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_BOTTOM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_COLS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_ROWS   = 3'd6;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               in_region;
      logic               last;
   } meta_type;

   typedef struct packed {
      logic                     valid;
      logic signed [COEF_W-1:0] acc;
      logic [WIN_W-1:0]         win;
      meta_type                 meta;
   } cell_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      meta_type         meta;
   } rsp_type;

endpackage

### rtl/c3x3f_tap_cell.sv
// One multiply and saturating-add cell of the 3x3 filter chain.
// Depends on c3x3f_pkg.
module c3x3f_tap_cell #(
   parameter int TAP = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [c3x3f_pkg::COEF_W-1:0]  coef,
   input  c3x3f_pkg::cell_type           up_cell,
   output c3x3f_pkg::cell_type           down_cell
);
   import c3x3f_pkg::*;

   logic [PIX_W-1:0]          pix;
   logic [COEF_W+PIX_W-1:0]   prod;
   logic signed [COEF_W-1:0]  prod_lo;
   logic signed [COEF_W:0]    sum;
   cell_type                  cell_in;
   cell_type                  cell_ff;

   assign pix     = up_cell.win[PIX_W*TAP +: PIX_W];
   assign prod    = {{PIX_W{1'b0}}, coef} * {{COEF_W{1'b0}}, pix};
   assign prod_lo = signed'(prod[COEF_W-1:0]);
   assign sum     = {up_cell.acc[COEF_W-1], up_cell.acc} + {prod_lo[COEF_W-1], prod_lo};

   always_comb begin
      cell_in = up_cell;
      // saturate on signed overflow of the 16-bit sum
      if (sum[COEF_W] != sum[COEF_W-1]) begin
         cell_in.acc = sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
      end else begin
         cell_in.acc = sum[COEF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign down_cell = cell_ff;

endmodule

### rtl/c3x3f_line_store.sv
// Line store of the 3x3 filter: one word per column holding the two previous lines.
// Depends on nothing; one write port, one registered read port.
module c3x3f_line_store #(
   parameter int DEPTH = 1024,
   parameter int DW    = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DW-1:0]            wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DW-1:0]            rdata
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/c3x3f_out_fifo.sv
// Two-entry result queue that decouples the filter chain from the result channel.
// Depends on c3x3f_pkg.
module c3x3f_out_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  c3x3f_pkg::rsp_type  push_item,
   input  logic                pop,
   output logic                out_valid,
   output c3x3f_pkg::rsp_type  out_item,
   output logic                full
);
   import c3x3f_pkg::*;

   rsp_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);

endmodule

### rtl/conv3x3_saturating_image_filter.sv
// Top level of the 3x3 saturating image filter: position counters, line store,
// window and a chain of nine tap cells. Depends on c3x3f_pkg, c3x3f_line_store,
// c3x3f_tap_cell and c3x3f_out_fifo.
//
//   channel  direction  handshake              payload
//   req_*    in         req_tvalid/req_tready  tdata: pixel_in; tuser: frame_start
//   rsp_*    out        rsp_tvalid/rsp_tready  tdata: pixel_out, centre_column,
//                                              centre_row; tuser: inside_region;
//                                              tlast: frame_end
//   csr_*    in         csr_we                 csr_index, csr_wdata
//
// One pixel is accepted every cycle while the chain is not held; a result leaves
// once the pixel that completes its window has passed the line store read, the
// nine tap cells and the result queue. Reset is synchronous and clears counters,
// window, valid bits and configuration to their defaults; the line store is not
// cleared. The whole chain holds only when a result sits at the chain end and the
// two-entry result queue is full; a single waiting result does not stop input.
module conv3x3_saturating_image_filter #(
   parameter int MAX_LINE_PIXELS = 1024,
   parameter int MAX_LINES       = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input item stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] pixel_in
   input  logic                                 req_tuser,  // [0] frame_start
   // result item stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [c3x3f_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [7:0] pixel_out,
                                                            // [17:8] centre_column,
                                                            // [27:18] centre_row,
                                                            // [31:28] zero
   output logic                                 rsp_tuser,  // [0] inside_region
   output logic                                 rsp_tlast,  // frame_end
   // configuration writes
   input  logic                                 csr_we,
   input  logic [c3x3f_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [c3x3f_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import c3x3f_pkg::*;

   localparam int CW = $clog2(MAX_LINE_PIXELS);
   localparam int RW = $clog2(MAX_LINES);
   localparam int WW = $clog2(MAX_LINE_PIXELS + 1);
   localparam int HW = $clog2(MAX_LINES + 1);
   localparam int LS_W = 2 * PIX_W;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [KROW_W-1:0] kernel_top_ff, kernel_middle_ff, kernel_bottom_ff;
   logic [10:0]       image_width_ff, image_height_ff;
   logic [31:0]       region_cols_ff, region_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_top_ff    <= 48'hFFFF_FFFF_FFFF;
         kernel_middle_ff <= 48'hFFFF_0009_FFFF;
         kernel_bottom_ff <= 48'hFFFF_FFFF_FFFF;
         image_width_ff   <= 11'd256;
         image_height_ff  <= 11'd256;
         region_cols_ff   <= 32'h0100_0000;
         region_rows_ff   <= 32'h0100_0000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KERNEL_TOP:    kernel_top_ff    <= csr_wdata;
            CSR_KERNEL_MIDDLE: kernel_middle_ff <= csr_wdata;
            CSR_KERNEL_BOTTOM: kernel_bottom_ff <= csr_wdata;
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata[10:0];
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata[10:0];
            CSR_REGION_COLS:   region_cols_ff   <= csr_wdata[31:0];
            CSR_REGION_ROWS:   region_rows_ff   <= csr_wdata[31:0];
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   // Clamp the line geometry to 3..MAX.
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;

   always_comb begin
      if (image_width_ff < 11'd3) begin
         w_eff = WW'(3);
      end else if (32'(image_width_ff) > MAX_LINE_PIXELS) begin
         w_eff = WW'(MAX_LINE_PIXELS);
      end else begin
         w_eff = WW'(image_width_ff);
      end
      if (image_height_ff < 11'd3) begin
         h_eff = HW'(3);
      end else if (32'(image_height_ff) > MAX_LINES) begin
         h_eff = HW'(MAX_LINES);
      end else begin
         h_eff = HW'(image_height_ff);
      end
   end

   // Region test: a start of 0 counts as 1, an end equal to the size as size-1.
   function automatic logic in_span(input logic [15:0] pos, input logic [31:0] span,
                                    input logic [15:0] size);
      logic [15:0] start;
      logic [15:0] stop;
      start = span[15:0];
      stop  = span[31:16];
      if (start == 16'd0) start = 16'd1;
      if (stop == size) stop = size - 16'd1;
      return (pos >= start) && (pos < stop);
   endfunction

   // ------------------------------------------------------------------
   // accept stage: position counters and line store read
   // ------------------------------------------------------------------
   logic          en;
   logic          accept;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] c_cur, cc;
   logic [RW-1:0] r_cur, cr;
   logic          emit, last_col, last_row;
   meta_type      meta_in;

   assign accept = req_tvalid && en;
   assign req_tready = en;

   always_comb begin
      c_cur    = req_tuser ? '0 : col_ff;
      r_cur    = req_tuser ? '0 : row_ff;
      cc       = c_cur - CW'(1);
      cr       = r_cur - RW'(1);
      emit     = (c_cur >= CW'(2)) && (r_cur >= RW'(2));
      last_col = (({1'b0, c_cur} + (CW+1)'(1)) >= (CW+1)'(w_eff));
      last_row = (({1'b0, r_cur} + (RW+1)'(1)) >= (RW+1)'(h_eff));
      meta_in.col       = COORD_W'(cc);
      meta_in.row       = COORD_W'(cr);
      meta_in.in_region = in_span(16'(cc), region_cols_ff, 16'(w_eff))
                          && in_span(16'(cr), region_rows_ff, 16'(h_eff));
      meta_in.last      = (({1'b0, c_cur} + (CW+1)'(1)) == (CW+1)'(w_eff))
                          && (({1'b0, r_cur} + (RW+1)'(1)) == (RW+1)'(h_eff));
      // advance raster position, wrapping at line and frame end
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : (r_cur + RW'(1));
      end else begin
         col_in = c_cur + CW'(1);
         row_in = r_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // window stage: line store word is {upper, lower}
   // ------------------------------------------------------------------
   logic             s1_valid_ff;
   logic [CW-1:0]    s1_addr_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic             s1_emit_ff;
   meta_type         s1_meta_ff;
   logic             fwd_hit_ff, fwd_hit_in;
   logic [LS_W-1:0]  fwd_word_ff;
   logic [LS_W-1:0]  ls_rdata, ls_word, ls_wdata;
   logic             ls_we;

   // The word read in the same cycle as a write to that column is stale: forward.
   assign ls_word    = fwd_hit_ff ? fwd_word_ff : ls_rdata;
   assign ls_wdata   = {ls_word[PIX_W-1:0], s1_pix_ff};
   assign ls_we      = en && s1_valid_ff;
   assign fwd_hit_in = accept && s1_valid_ff && (c_cur == s1_addr_ff);

   c3x3f_line_store #(
      .DEPTH (MAX_LINE_PIXELS),
      .DW    (LS_W)
   ) u_line_store (
      .clock (clock),
      .we    (ls_we),
      .waddr (s1_addr_ff),
      .wdata (ls_wdata),
      .re    (accept),
      .raddr (c_cur),
      .rdata (ls_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
         fwd_hit_ff  <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff  <= c_cur;
         s1_pix_ff   <= req_tdata;
         s1_emit_ff  <= emit;
         s1_meta_ff  <= meta_in;
         fwd_word_ff <= ls_wdata;
      end
   end

   // Shift the window one column left and load upper, lower and new pixel on the right.
   logic [WIN_W-1:0] window_ff, window_in;
   logic [PIX_W-1:0] new_col [3];

   assign new_col[0] = ls_word[LS_W-1:PIX_W];
   assign new_col[1] = ls_word[PIX_W-1:0];
   assign new_col[2] = s1_pix_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         window_in[PIX_W*(3*i)   +: PIX_W] = window_ff[PIX_W*(3*i+1) +: PIX_W];
         window_in[PIX_W*(3*i+1) +: PIX_W] = window_ff[PIX_W*(3*i+2) +: PIX_W];
         window_in[PIX_W*(3*i+2) +: PIX_W] = new_col[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (ls_we) begin
         window_ff <= window_in;
      end
   end

   // ------------------------------------------------------------------
   // tap cell chain: cell t adds coefficient t times window pixel t
   // ------------------------------------------------------------------
   logic [KROW_W-1:0] kernel_rows [3];
   cell_type          chain [TAPS+1];

   assign kernel_rows[0] = kernel_top_ff;
   assign kernel_rows[1] = kernel_middle_ff;
   assign kernel_rows[2] = kernel_bottom_ff;

   always_comb begin
      chain[0].valid = s1_valid_ff && s1_emit_ff;
      chain[0].acc   = '0;
      chain[0].win   = window_in;
      chain[0].meta  = s1_meta_ff;
   end

   for (genvar t = 0; t < TAPS; t++) begin : g_tap
      c3x3f_tap_cell #(
         .TAP (t)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .coef      (kernel_rows[t/3][COEF_W*(t%3) +: COEF_W]),
         .up_cell   (chain[t]),
         .down_cell (chain[t+1])
      );
   end

   // ------------------------------------------------------------------
   // clamp, region mux and result queue
   // ------------------------------------------------------------------
   rsp_type result;
   rsp_type out_item;
   logic    fifo_full;
   logic    push;

   always_comb begin
      result.meta = chain[TAPS].meta;
      if (!chain[TAPS].meta.in_region || chain[TAPS].acc < 0) begin
         result.pixel = '0;
      end else if (chain[TAPS].acc > signed'({8'd0, PIX_MAX})) begin
         result.pixel = PIX_MAX;
      end else begin
         result.pixel = chain[TAPS].acc[PIX_W-1:0];
      end
   end

   // Hold the whole chain only when its end has a result and the queue is full.
   assign en   = !chain[TAPS].valid || !fifo_full;
   assign push = chain[TAPS].valid && !fifo_full;

   c3x3f_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (result),
      .pop       (rsp_tvalid && rsp_tready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item),
      .full      (fifo_full)
   );

   assign rsp_tdata = {(RSP_DATA_W - PIX_W - 2*COORD_W)'(0), out_item.meta.row,
                       out_item.meta.col, out_item.pixel};
   assign rsp_tuser = out_item.meta.in_region;
   assign rsp_tlast = out_item.meta.last;

endmodule

### rtl/c3x3f_checker.sv
// Port-level checks of the 3x3 image filter, bound to the top level.
// Depends on c3x3f_pkg and conv3x3_saturating_image_filter_defines.svh.
`include "conv3x3_saturating_image_filter_defines.svh"

module c3x3f_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [c3x3f_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                              rsp_tuser,
   input  logic                              rsp_tlast
);
   import c3x3f_pkg::*;

   // a stalled result keeps its valid, its data and its last flag
   `C3X3F_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // a centre outside the region gives a zero pixel
   `C3X3F_ASSERT_NOW(a_outside_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[PIX_W-1:0] == '0)

   // nothing is shown in the cycle after reset
   `C3X3F_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_tvalid)

   // the padding above the packed fields stays zero
   `C3X3F_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[RSP_DATA_W-1:PIX_W+2*COORD_W] == '0)

endmodule

bind conv3x3_saturating_image_filter c3x3f_checker u_c3x3f_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
